// File: design/bit_block_interleaver_macros.svh
// Assertion macros for the bit block interleaver.
// Included by the top level; no other dependencies.
`ifndef BIT_BLOCK_INTERLEAVER_MACROS_SVH
`define BIT_BLOCK_INTERLEAVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bbi_pkg.sv
// Shared types and constants of the bit block interleaver.
// No dependencies; imported by bbi_in_if, bbi_front, bbi_div, bbi_back and the top level.
package bbi_pkg;

  localparam int FRAME_BITS = 4096;
  localparam int ADDR_W     = $clog2(FRAME_BITS);
  localparam int CFG_W      = 13;
  localparam int ROW_W      = 12;
  localparam int PROD_W     = ROW_W + CFG_W;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_CNT_W  = $clog2(CFG_W + 1);

  // The queue depth must be a power of two, the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PULL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd2;

  localparam int RESET_COLUMNS      = 1;
  localparam int RESET_FRAME_LENGTH = 4096;
  localparam int RESET_REM          = RESET_FRAME_LENGTH % RESET_COLUMNS;
  localparam int RESET_ROWS         = (RESET_FRAME_LENGTH + RESET_COLUMNS - 1) / RESET_COLUMNS;
  localparam int RESET_LAST_FULL    = (RESET_REM == 0) ? RESET_COLUMNS : RESET_REM - 1;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PULL,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t  op;
    logic data;
  } q_item_t;

  // Effective configuration, with out-of-range values already folded in.
  typedef struct packed {
    logic [CFG_W-1:0] columns;
    logic [CFG_W-1:0] frame_length;
    logic             direction;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } ram_req_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CFG_W-1:0] quotient;
    logic [CFG_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: design/bbi_in_if.sv
// Input channel of the bit block interleaver: command and data bit.
// Depends on bbi_pkg.
interface bbi_in_if import bbi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic             in_bit;

  modport source (output valid, output cmd, output in_bit, input ready);
  modport sink (input valid, input cmd, input in_bit, output ready);
endinterface

// File: design/bbi_out_if.sv
// Result channel of the bit block interleaver: pulled bit and flags.
// No dependencies.
interface bbi_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic frame_last;
  logic overrun;

  modport source (output valid, output out_bit, output frame_last, output overrun,
                  input ready);
  modport sink (input valid, input out_bit, input frame_last, input overrun,
                output ready);
endinterface

// File: design/bbi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/bbi_front.sv
// Front end: takes command transfers, decodes them and queues them for the back end.
// Depends on bbi_pkg and bbi_in_if.
module bbi_front import bbi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bbi_in_if.sink   items,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_ready
);

  q_item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;
  q_item_t             decoded;
  logic                keep;
  logic                push;
  logic                pop;

  // An unused command code is taken and dropped here.
  always_comb begin
    decoded.data = items.in_bit;
    keep         = 1'b1;
    case (items.cmd)
      CMD_PUSH:    decoded.op = OP_PUSH;
      CMD_PULL:    decoded.op = OP_PULL;
      CMD_RESTART: decoded.op = OP_RESTART;
      default: begin
        decoded.op = OP_PUSH;
        keep       = 1'b0;
      end
    endcase
  end

  assign items.ready = (count != QCOUNT_W'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready && keep;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/bbi_div.sv
// Radix-2 restoring divider used at a frame restart, one quotient bit per cycle.
// Depends on bbi_pkg.
module bbi_div import bbi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CFG_W-1:0]     quo;
  logic [CFG_W-1:0]     rem;
  logic [CFG_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [CFG_W:0]       shifted;
  logic [CFG_W:0]       diff;
  logic                 take;

  assign shifted = {rem, quo[CFG_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign take    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= DIV_CNT_W'(CFG_W);
        busy    <= 1'b1;
      end else if (busy) begin
        quo <= {quo[CFG_W-2:0], take};
        rem <= take ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: design/bbi_back.sv
// Back end: walks the frame pointers, drives the bit store and the divider,
// and holds the result register. Depends on bbi_pkg and bbi_out_if.
module bbi_back import bbi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_ready,
  output ram_req_t  ram_req,
  input  logic      ram_rdata,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  bbi_out_if.source results
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_ACCESS,
    S_WAIT,
    S_RESULT
  } state_t;

  state_t            state;
  op_t               op;
  logic              data;
  logic [CFG_W-1:0]  natural_pos;
  logic [CFG_W-1:0]  perm_count;
  logic [ROW_W-1:0]  cur_row;
  logic [CFG_W-1:0]  cur_col;
  logic [CFG_W-1:0]  rows_in_column;
  logic [CFG_W-1:0]  last_full_column;
  logic [PROD_W-1:0] prod;
  logic              res_zero;
  logic              res_last;
  logic              res_over;
  logic              out_valid;
  logic              out_bit;
  logic              frame_last;
  logic              overrun;

  logic              uses_perm;
  logic [CFG_W-1:0]  ptr;
  logic              in_range;
  logic              last_hit;
  logic [PROD_W-1:0] addr_full;
  logic              addr_ok;
  logic [CFG_W-1:0]  row_inc;
  logic              wrap;

  always_comb begin
    uses_perm = (op == OP_PUSH) ? cfg.direction : !cfg.direction;
    ptr       = uses_perm ? perm_count : natural_pos;
    in_range  = (ptr < cfg.frame_length);
    last_hit  = ((ptr + 1'b1) == cfg.frame_length);
    addr_full = uses_perm ? prod + PROD_W'(cur_col) : PROD_W'(natural_pos);
    addr_ok   = (addr_full < PROD_W'(FRAME_BITS));
    row_inc   = {1'b0, cur_row} + 1'b1;
    wrap      = (row_inc >= rows_in_column);
  end

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      natural_pos      <= '0;
      perm_count       <= '0;
      cur_row          <= '0;
      cur_col          <= '0;
      rows_in_column   <= CFG_W'(RESET_ROWS);
      last_full_column <= CFG_W'(RESET_LAST_FULL);
      ram_req          <= '0;
      div_req          <= '0;
      out_valid        <= 1'b0;
    end else begin
      // The strobes follow from the current state, so each is set once a cycle.
      ram_req.we    <= (state == S_ACCESS) && (op == OP_PUSH) && in_range && addr_ok;
      ram_req.re    <= (state == S_ACCESS) && (op != OP_PUSH) && in_range && addr_ok;
      div_req.start <= (state == S_IDLE) && q_valid && (q_item.op == OP_RESTART);
      if (results.ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op   <= q_item.op;
            data <= q_item.data;
            case (q_item.op)
              OP_RESTART: begin
                div_req.dividend <= cfg.frame_length;
                div_req.divisor  <= cfg.columns;
                state            <= S_DIV;
              end
              OP_PUSH, OP_PULL: state <= S_MUL;
              default:          state <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            natural_pos <= '0;
            perm_count  <= '0;
            cur_row     <= '0;
            cur_col     <= '0;
            if (div_rsp.remainder == '0) begin
              rows_in_column   <= div_rsp.quotient;
              last_full_column <= div_req.divisor;
            end else begin
              rows_in_column   <= div_rsp.quotient + 1'b1;
              last_full_column <= div_rsp.remainder - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= cur_row * cfg.columns;
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          ram_req.addr  <= addr_full[ADDR_W-1:0];
          ram_req.wdata <= data;
          if (op == OP_PUSH) begin
            state <= S_IDLE;
          end else begin
            res_zero <= !(in_range && addr_ok);
            res_last <= in_range && last_hit;
            res_over <= !in_range;
            state    <= in_range ? S_WAIT : S_RESULT;
          end
          if (in_range) begin
            if (uses_perm) begin
              perm_count <= perm_count + 1'b1;
              if (wrap) begin
                cur_row <= '0;
                cur_col <= cur_col + 1'b1;
                if (cur_col == last_full_column && rows_in_column != '0) begin
                  rows_in_column <= rows_in_column - 1'b1;
                end
              end else begin
                cur_row <= row_inc[ROW_W-1:0];
              end
            end else begin
              natural_pos <= natural_pos + 1'b1;
            end
          end
        end
        S_WAIT: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || results.ready) begin
            out_bit    <= !res_zero && ram_rdata;
            frame_last <= res_last;
            overrun    <= res_over;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid      = out_valid;
  assign results.out_bit    = out_bit;
  assign results.frame_last = frame_last;
  assign results.overrun    = overrun;

endmodule

// File: design/bit_block_interleaver.sv
// Bit block interleaver: a row-column permutation over a 4096-bit store.
// A push steps the back end through S_MUL and S_ACCESS; a pull goes on through
// S_WAIT (skipped on an overrun) to S_RESULT, where it may wait for the result register.
// A restart waits in S_DIV for the radix-2 divider that works out the
// row count, one quotient bit per cycle, for a 13-bit quotient.
// Synchronous reset clears the pointers and the queue; the bit store is not cleared.
`include "bit_block_interleaver_macros.svh"

module bit_block_interleaver import bbi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bbi_in_if.sink               items,
  bbi_out_if.source            results,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers as written. The effective values below fold a
  // zero column count or frame length to one and clamp the frame length to
  // the store size; the back end only ever sees the effective values.
  logic [CFG_W-1:0] columns;
  logic [CFG_W-1:0] frame_length;
  logic             direction;
  cfg_t             cfg;

  // Queue between the front end and the back end.
  logic     q_valid;
  logic     q_ready;
  q_item_t  q_item;

  // Bit store access and divider handshake, both driven by the back end.
  ram_req_t ram_req;
  logic     ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= CFG_W'(RESET_COLUMNS);
      frame_length <= CFG_W'(RESET_FRAME_LENGTH);
      direction    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLUMNS:      columns      <= cfg_data;
        REG_FRAME_LENGTH: frame_length <= cfg_data;
        REG_DIRECTION:    direction    <= cfg_data[0];
        default:          direction    <= direction;
      endcase
    end
  end

  always_comb begin
    cfg.columns   = (columns == '0) ? CFG_W'(1) : columns;
    cfg.direction = direction;
    if (frame_length == '0) begin
      cfg.frame_length = CFG_W'(1);
    end else if (frame_length > CFG_W'(FRAME_BITS)) begin
      cfg.frame_length = CFG_W'(FRAME_BITS);
    end else begin
      cfg.frame_length = frame_length;
    end
  end

  // The front end accepts a transfer whenever its queue has room, so the
  // upstream side never waits on the back end while the queue is not full.
  bbi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  bbi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // The back end performs at most one access per item, so a single shared address
  // serves both the write and the read port of the store.
  bbi_ram #(
    .WIDTH (1),
    .DEPTH (FRAME_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  // The back end holds the result register, so a finished result may wait
  // for its transfer while the front end keeps taking commands.
  bbi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .results   (results)
  );

  // The store is never written and read in the same cycle.
  `BBI_ASSERT_SAME(a_single_access, clk, rst, ram_req.we, !ram_req.re, "store written and read together")

  // A restart must not start the divider while it is still working.
  `BBI_ASSERT_SAME(a_div_idle_start, clk, rst, div_rsp.busy, !div_req.start, "divider started while busy")

  // An overrun result carries neither a data bit nor an end-of-frame mark.
  `BBI_ASSERT_SAME(a_overrun_clean, clk, rst, results.valid && results.overrun, !results.out_bit && !results.frame_last, "overrun result with data")

  // Reads are spaced so the registered read data holds until it is used.
  `BBI_ASSERT_NEXT(a_read_spacing, clk, rst, ram_req.re, !ram_req.re, "back-to-back store reads")

endmodule
